### design/rth_pkg.sv
// ---------------------------------------------------------------------------
// rth_pkg
// Shared widths, constants and types for the RGB to hue core and its checker.
// ---------------------------------------------------------------------------
package rth_pkg;

   localparam int unsigned CHAN_W         = 8;   // colour channel
   localparam int unsigned DIFF_W         = 9;   // signed channel difference
   localparam int unsigned SUM_W          = 12;  // signed k*c + d
   localparam int unsigned MAG_W          = 11;  // |k*c + d|, at most 5*255
   localparam int unsigned NUM_W          = 17;  // 85*|k*c + d| + c
   localparam int unsigned DEN_W          = 9;   // 2*c
   localparam int unsigned QUO_W          = 8;   // hue magnitude
   localparam int unsigned DIV_STAGES     = 4;
   localparam int unsigned BITS_PER_STAGE = QUO_W / DIV_STAGES;

   // accept edge to result strobe
   localparam int unsigned PIPE_LATENCY   = 5 + DIV_STAGES;

   localparam logic [NUM_W-1:0]  HUE_SCALE  = 17'd85;
   localparam logic [QUO_W-1:0]  HUE_GREEN  = 8'd85;
   localparam logic [QUO_W-1:0]  HUE_BLUE   = 8'd170;

   typedef enum logic [1:0] {
      SEL_RED,
      SEL_GREEN,
      SEL_BLUE
   } max_sel_type;

endpackage

### design/rgb_to_hue_8bit_core.sv
// ---------------------------------------------------------------------------
// rgb_to_hue_8bit_core
// HSV hue of an 8-bit RGB pixel, 0..255 over a full turn.
// ---------------------------------------------------------------------------
// A pixel word is taken on every clock in which start is high and busy is
// low; busy is only high while reset is held. Each word gives one hue on
// rsp_hue, marked by rsp_strobe, and one word per clock is sustained. The
// pipeline runs through the input register, max/min and chroma, offset add,
// constant multiply, four stages of a restoring divider retiring two
// quotient bits each, and the output register. The result strobe is not
// held, so the receiver must take every word in the cycle it appears.
// ---------------------------------------------------------------------------
module rgb_to_hue_8bit_core
   import rth_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CHAN_W-1:0] req_red,
   input  logic [CHAN_W-1:0] req_green,
   input  logic [CHAN_W-1:0] req_blue,
   output logic              rsp_strobe,
   output logic [QUO_W-1:0]  rsp_hue
);

   // stage 1: input register
   logic              s1_valid_ff;
   logic [CHAN_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff;

   // stage 2: max, min, chroma, difference
   logic                     s2_valid_ff;
   max_sel_type              s2_sel_ff, s2_sel_in;
   logic [CHAN_W-1:0]        s2_c_ff, s2_c_in;
   logic signed [DIFF_W-1:0] s2_d_ff, s2_d_in;
   logic [CHAN_W-1:0]        mx, mn;

   // stage 3: offset added, magnitude and sign
   logic                    s3_valid_ff;
   logic [MAG_W-1:0]        s3_mag_ff, s3_mag_in;
   logic [CHAN_W-1:0]       s3_c_ff;
   logic                    s3_neg_ff, s3_neg_in;
   logic                    s3_zero_ff;
   logic signed [SUM_W-1:0] kc, t_sum;

   // stage 4: numerator and divisor
   logic              s4_valid_ff;
   logic [NUM_W-1:0]  s4_num_ff, s4_num_in;
   logic [DEN_W-1:0]  s4_den_ff;
   logic              s4_neg_ff, s4_zero_ff;

   // divider stages
   logic              dv_valid_ff [DIV_STAGES];
   logic [NUM_W-1:0]  dv_rem_ff   [DIV_STAGES];
   logic [QUO_W-1:0]  dv_quo_ff   [DIV_STAGES];
   logic [DEN_W-1:0]  dv_den_ff   [DIV_STAGES];
   logic              dv_neg_ff   [DIV_STAGES];
   logic              dv_zero_ff  [DIV_STAGES];

   // output
   logic              rsp_strobe_ff;
   logic [QUO_W-1:0]  rsp_hue_ff, rsp_hue_in;

   assign busy = reset;

   // ---- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_red_ff   <= req_red;
      s1_green_ff <= req_green;
      s1_blue_ff  <= req_blue;
   end

   // ---- stage 2
   always_comb begin
      if (s1_red_ff >= s1_green_ff && s1_red_ff >= s1_blue_ff) begin
         s2_sel_in = SEL_RED;
         mx        = s1_red_ff;
      end else if (s1_green_ff >= s1_blue_ff) begin
         s2_sel_in = SEL_GREEN;
         mx        = s1_green_ff;
      end else begin
         s2_sel_in = SEL_BLUE;
         mx        = s1_blue_ff;
      end
      mn = s1_red_ff;
      if (s1_green_ff < mn) begin
         mn = s1_green_ff;
      end
      if (s1_blue_ff < mn) begin
         mn = s1_blue_ff;
      end
      s2_c_in = mx - mn;
      unique case (s2_sel_in)
         SEL_RED:   s2_d_in = $signed(DIFF_W'(s1_green_ff)) - $signed(DIFF_W'(s1_blue_ff));
         SEL_GREEN: s2_d_in = $signed(DIFF_W'(s1_blue_ff)) - $signed(DIFF_W'(s1_red_ff));
         SEL_BLUE:  s2_d_in = $signed(DIFF_W'(s1_red_ff)) - $signed(DIFF_W'(s1_green_ff));
         default:   s2_d_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_sel_ff <= s2_sel_in;
      s2_c_ff   <= s2_c_in;
      s2_d_ff   <= s2_d_in;
   end

   // ---- stage 3
   always_comb begin
      unique case (s2_sel_ff)
         SEL_RED:   kc = '0;
         SEL_GREEN: kc = $signed(SUM_W'({s2_c_ff, 1'b0}));
         SEL_BLUE:  kc = $signed(SUM_W'({s2_c_ff, 2'b00}));
         default:   kc = '0;
      endcase
      t_sum     = kc + SUM_W'(s2_d_ff);
      s3_neg_in = t_sum[SUM_W-1];
      s3_mag_in = s3_neg_in ? MAG_W'(-t_sum) : MAG_W'(t_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_mag_ff  <= s3_mag_in;
      s3_c_ff    <= s2_c_ff;
      s3_neg_ff  <= s3_neg_in;
      s3_zero_ff <= (s2_c_ff == '0);
   end

   // ---- stage 4: 85*|t| + c, the +c gives half-away rounding
   assign s4_num_in = NUM_W'(s3_mag_ff) * HUE_SCALE + NUM_W'(s3_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_num_ff  <= s4_num_in;
      s4_den_ff  <= {s3_c_ff, 1'b0};
      s4_neg_ff  <= s3_neg_ff;
      s4_zero_ff <= s3_zero_ff;
   end

   // ---- restoring divider, two quotient bits a stage
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      logic              valid_src;
      logic [NUM_W-1:0]  rem_src;
      logic [QUO_W-1:0]  quo_src;
      logic [DEN_W-1:0]  den_src;
      logic              neg_src, zero_src;
      logic [NUM_W-1:0]  rem_in;
      logic [QUO_W-1:0]  quo_in;
      logic [NUM_W-1:0]  den_sh;

      if (j == 0) begin : g_first
         assign valid_src = s4_valid_ff;
         assign rem_src   = s4_num_ff;
         assign quo_src   = '0;
         assign den_src   = s4_den_ff;
         assign neg_src   = s4_neg_ff;
         assign zero_src  = s4_zero_ff;
      end else begin : g_next
         assign valid_src = dv_valid_ff[j-1];
         assign rem_src   = dv_rem_ff[j-1];
         assign quo_src   = dv_quo_ff[j-1];
         assign den_src   = dv_den_ff[j-1];
         assign neg_src   = dv_neg_ff[j-1];
         assign zero_src  = dv_zero_ff[j-1];
      end

      always_comb begin
         rem_in = rem_src;
         quo_in = quo_src;
         den_sh = '0;
         for (int s = 0; s < BITS_PER_STAGE; s++) begin
            den_sh = NUM_W'(den_src) << (QUO_W - 1 - j * BITS_PER_STAGE - s);
            if (rem_in >= den_sh) begin
               rem_in = rem_in - den_sh;
               quo_in = quo_in | (QUO_W'(1) << (QUO_W - 1 - j * BITS_PER_STAGE - s));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= valid_src;
         end
         dv_rem_ff[j]  <= rem_in;
         dv_quo_ff[j]  <= quo_in;
         dv_den_ff[j]  <= den_src;
         dv_neg_ff[j]  <= neg_src;
         dv_zero_ff[j] <= zero_src;
      end
   end

   // ---- output: grey gives 0, negative hue wraps mod 256
   always_comb begin
      if (dv_zero_ff[DIV_STAGES-1]) begin
         rsp_hue_in = '0;
      end else if (dv_neg_ff[DIV_STAGES-1]) begin
         rsp_hue_in = -dv_quo_ff[DIV_STAGES-1];
      end else begin
         rsp_hue_in = dv_quo_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_valid_ff[DIV_STAGES-1];
      end
      rsp_hue_ff <= rsp_hue_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_hue    = rsp_hue_ff;

endmodule

### design/rth_checker.sv
// ---------------------------------------------------------------------------
// rth_checker
// Port-level checks on the RGB to hue core: fixed latency and known hues.
// ---------------------------------------------------------------------------
module rth_checker
   import rth_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [CHAN_W-1:0] req_red,
   input logic [CHAN_W-1:0] req_green,
   input logic [CHAN_W-1:0] req_blue,
   input logic              rsp_strobe,
   input logic [QUO_W-1:0]  rsp_hue
);

   logic accept;
   assign accept = start && !busy;

   // every taken word gives exactly one result, at fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_LATENCY rsp_strobe)
      else $error("word taken but no result at expected latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##PIPE_LATENCY !rsp_strobe)
      else $error("result strobe without a taken word");

   a_grey_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_red == req_green && req_green == req_blue)
      |-> ##PIPE_LATENCY (rsp_hue == '0))
      else $error("grey pixel gave non-zero hue");

   a_pure_green: assert property (@(posedge clock) disable iff (reset)
      (accept && req_red == '0 && req_blue == '0 && req_green != '0)
      |-> ##PIPE_LATENCY (rsp_hue == HUE_GREEN))
      else $error("pure green gave wrong hue");

   a_pure_blue: assert property (@(posedge clock) disable iff (reset)
      (accept && req_red == '0 && req_green == '0 && req_blue != '0)
      |-> ##PIPE_LATENCY (rsp_hue == HUE_BLUE))
      else $error("pure blue gave wrong hue");

endmodule

bind rgb_to_hue_8bit_core rth_checker u_rth_checker (.*);

### tb/rgb_to_hue_8bit_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_to_hue_8bit_core_tb
// Self-checking bench for the RGB to hue core.
// ---------------------------------------------------------------------------
// Pixel words go in through the start/busy handshake with random idle gaps
// and bursts at full rate. Every hue strobed out is matched in order against
// a queue of expected hues. A short table of corner pixels comes first: grey,
// primaries, tied maxima, the negative wrap and exact halves. About 1100
// random pixels follow, weighted towards greys, ties, small chroma and
// saturated channels.
// ---------------------------------------------------------------------------
module rgb_to_hue_8bit_core_tb;
   import rth_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              known;
      logic [QUO_W-1:0]  hue;
   } pixel_word_type;

   localparam int N_CORNER  = 23;
   localparam int N_RANDOM  = 1100;
   localparam int MAX_SHOWN = 10;

   localparam pixel_word_type CORNER_TAB [N_CORNER] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
      '{8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
      '{8'd128, 8'd128, 8'd128, 1'b1, 8'd0},
      '{8'd255, 8'd0,   8'd0,   1'b1, 8'd0},
      '{8'd0,   8'd255, 8'd0,   1'b1, 8'd85},
      '{8'd0,   8'd0,   8'd255, 1'b1, 8'd170},
      '{8'd255, 8'd255, 8'd0,   1'b1, 8'd43},
      '{8'd0,   8'd255, 8'd255, 1'b1, 8'd128},
      '{8'd255, 8'd0,   8'd255, 1'b1, 8'd213},
      '{8'd1,   8'd1,   8'd0,   1'b1, 8'd43},
      '{8'd1,   8'd0,   8'd1,   1'b1, 8'd213},
      '{8'd0,   8'd1,   8'd0,   1'b1, 8'd85},
      '{8'd1,   8'd0,   8'd0,   1'b1, 8'd0},
      '{8'd255, 8'd0,   8'd1,   1'b0, 8'd0},
      '{8'd255, 8'd1,   8'd0,   1'b0, 8'd0},
      '{8'd255, 8'd0,   8'd254, 1'b0, 8'd0},
      '{8'd254, 8'd255, 8'd0,   1'b0, 8'd0},
      '{8'd0,   8'd254, 8'd255, 1'b0, 8'd0},
      '{8'd255, 8'd254, 8'd255, 1'b0, 8'd0},
      '{8'd170, 8'd85,  8'd0,   1'b0, 8'd0},
      '{8'd85,  8'd170, 8'd255, 1'b0, 8'd0},
      '{8'd0,   8'd0,   8'd1,   1'b0, 8'd0},
      '{8'd255, 8'd128, 8'd0,   1'b0, 8'd0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [CHAN_W-1:0] req_red   = '0;
   logic [CHAN_W-1:0] req_green = '0;
   logic [CHAN_W-1:0] req_blue  = '0;
   logic              rsp_strobe;
   logic [QUO_W-1:0]  rsp_hue;

   pixel_word_type    drv_word   = '0;
   pixel_word_type    taken_word = '0;
   logic              taken      = 1'b0;
   pixel_word_type    hue_queue [$];

   int                words_sent   = 0;
   int                hues_checked = 0;
   int                errors       = 0;
   int                greys        = 0;
   int                wraps        = 0;

   rgb_to_hue_8bit_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .rsp_strobe (rsp_strobe),
      .rsp_hue    (rsp_hue)
   );

   always #5 clock = ~clock;

   function automatic logic [QUO_W-1:0] hue_of_pixel(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b);
      int hi, lo, chroma, offs, diff, num, den, q;
      hi = int'(r);
      lo = int'(r);
      if (int'(g) > hi) hi = int'(g);
      if (int'(b) > hi) hi = int'(b);
      if (int'(g) < lo) lo = int'(g);
      if (int'(b) < lo) lo = int'(b);
      chroma = hi - lo;
      if (chroma == 0) return '0;
      if (hi == int'(r)) begin
         offs = 0;
         diff = int'(g) - int'(b);
      end else if (hi == int'(g)) begin
         offs = 2;
         diff = int'(b) - int'(r);
      end else begin
         offs = 4;
         diff = int'(r) - int'(g);
      end
      num = 85 * (offs * chroma + diff);
      den = 2 * chroma;
      if (num >= 0) q = (2 * num + den) / (2 * den);
      else q = -((2 * (-num) + den) / (2 * den));
      return QUO_W'(q);
   endfunction

   task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b, input logic known,
                             input logic [QUO_W-1:0] typed_hue, input int gap);
      pixel_word_type w;
      w.red   = r;
      w.green = g;
      w.blue  = b;
      w.known = known;
      w.hue   = known ? typed_hue : hue_of_pixel(r, g, b);
      if (r == g && g == b) greys++;
      if (r >= g && r >= b && b > g) wraps++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      drv_word  <= w;
      do @(posedge clock); while (busy !== 1'b0);
      words_sent++;
   endtask

   task automatic drain_hues();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      do @(negedge clock); while (hue_queue.size() != 0);
   endtask

   // acceptance is logged at the rising edge, the expectation queued at the falling edge
   always @(posedge clock) begin
      pixel_word_type e;
      taken      <= !reset && start && (busy === 1'b0);
      taken_word <= drv_word;
      if (!reset && rsp_strobe === 1'b1) begin
         if (hue_queue.size() == 0) begin
            if (errors < MAX_SHOWN)
               $display("%0t: unexpected hue word %0d", $realtime, rsp_hue);
            errors++;
         end else begin
            e = hue_queue.pop_front();
            hues_checked++;
            if (rsp_hue !== e.hue) begin
               if (errors < MAX_SHOWN)
                  $display("%0t: rgb (%0d,%0d,%0d) hue expected %0d got %0d",
                           $realtime, e.red, e.green, e.blue, e.hue, rsp_hue);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (taken) hue_queue.push_back(taken_word);
   end

   initial begin
      #2_000_000;
      $display("** rgb_to_hue_8bit_core: FAILED **");
      $finish;
   end

   initial begin
      logic [CHAN_W-1:0] r, g, b, top;
      int                kind, gap, pick;
      logic              burst;
      burst = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_CORNER; i++)
         send_pixel(CORNER_TAB[i].red, CORNER_TAB[i].green, CORNER_TAB[i].blue,
                    CORNER_TAB[i].known, CORNER_TAB[i].hue, $urandom_range(0, 3));

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 64 == 0) burst = ($urandom_range(0, 2) == 0);
         if (i == N_RANDOM / 2) drain_hues();
         kind = $urandom_range(0, 9);
         r = CHAN_W'($urandom);
         g = CHAN_W'($urandom);
         b = CHAN_W'($urandom);
         case (kind)
            0: begin
               g = r;
               b = r;
            end
            1: begin
               top  = CHAN_W'($urandom);
               pick = $urandom_range(0, 2);
               r = (pick == 2) ? CHAN_W'($urandom_range(0, top)) : top;
               g = (pick == 1) ? CHAN_W'($urandom_range(0, top)) : top;
               b = (pick == 0) ? CHAN_W'($urandom_range(0, top)) : top;
            end
            2: begin
               g = (r > 252) ? r - CHAN_W'($urandom_range(0, 3))
                             : r + CHAN_W'($urandom_range(0, 3));
               b = (r < 3) ? r + CHAN_W'($urandom_range(0, 3))
                           : r - CHAN_W'($urandom_range(0, 3));
            end
            3: begin
               if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
               if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
               if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default: ;
         endcase
         gap = burst ? 0 : $urandom_range(0, 9);
         send_pixel(r, g, b, 1'b0, '0, gap);
      end

      drain_hues();
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      $display("%0d pixel words sent, %0d hues checked, %0d mismatches",
               words_sent, hues_checked, errors);
      $display("covered %0d grey pixels and %0d red-max pixels needing the wrap",
               greys, wraps);
      if (errors == 0 && hue_queue.size() == 0) begin
         $display("** rgb_to_hue_8bit_core: PASSED **");
      end else begin
         $display("** rgb_to_hue_8bit_core: FAILED **");
      end
      $finish;
   end

endmodule
